// ----- sv/acpa_pkg.sv -----
// Package for the aligned contiguous page allocator.
// Holds region, operation and status codes and the page state record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acpa_pkg;

    localparam logic [1:0] REG_RESERVED = 2'd0;
    localparam logic [1:0] REG_KERNEL   = 2'd1;
    localparam logic [1:0] REG_NORMAL   = 2'd2;
    localparam logic [1:0] REG_HIGH     = 2'd3;

    localparam logic [2:0] OP_ADD_RANGE = 3'd0;
    localparam logic [2:0] OP_ALLOC     = 3'd1;
    localparam logic [2:0] OP_FREE      = 3'd2;
    localparam logic [2:0] OP_INCREF    = 3'd3;
    localparam logic [2:0] OP_DECREF    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_PAGE = 2'd2;
    localparam logic [1:0] ST_BOUNDS   = 2'd3;

    localparam logic CFG_KERNEL_END = 1'b0;
    localparam logic CFG_HIGH_START = 1'b1;

    typedef struct packed {
        logic       used;
        logic       blk_end;
        logic [1:0] region;
    } page_t;

endpackage
`default_nettype wire

// ----- sv/acpa_page_store.sv -----
// Per-page state memory and reference count memory, one port each.
// Read data is registered; depends on acpa_pkg for the page record.
`timescale 1ns / 1ps
`default_nettype none
module acpa_page_store #(
    parameter int NUM_PAGES = 1024,
    parameter int REF_WIDTH = 16,
    parameter int AW        = 10
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        addr,
    input  wire acpa_pkg::page_t      wpage,
    input  wire logic [REF_WIDTH-1:0] wref,
    output      acpa_pkg::page_t      rpage,
    output      logic [REF_WIDTH-1:0] rref
);
    import acpa_pkg::*;

    page_t                page_mem [NUM_PAGES];
    logic [REF_WIDTH-1:0] ref_mem  [NUM_PAGES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            page_mem[addr] <= wpage;
            ref_mem[addr]  <= wref;
        end
        rpage <= page_mem[addr];
        rref  <= ref_mem[addr];
    end

endmodule
`default_nettype wire

// ----- sv/aligned_contiguous_page_allocator_top.sv -----
// Top level of the aligned contiguous page allocator: command sequencer.
// Depends on acpa_pkg and acpa_page_store.
//
// One command at a time. After reset the block clears every page of its
// store with busy high. Each page visited takes a read state and then an
// evaluate/write state on the single store port: add_range visits each page
// of its range, free and decref each released page, incref one page; alloc
// scans for a free aligned run (the high region first, then the normal one,
// with prefer_high) and then marks the block page by page. The result
// is on the ports for one cycle with done high; it cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module aligned_contiguous_page_allocator_top #(
    parameter int NUM_PAGES = 1024,
    parameter int REF_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output      logic                 busy,
    output      logic                 done,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [10:0]          cfg_data,
    input  wire logic [2:0]           kind,
    input  wire logic [9:0]           page_index,
    input  wire logic [10:0]          page_count,
    input  wire logic [3:0]           align_log2,
    input  wire logic                 prefer_high,
    output      logic [1:0]           status,
    output      logic [9:0]           block_start,
    output      logic [10:0]          free_normal,
    output      logic [10:0]          free_high,
    output      logic [REF_WIDTH-1:0] ref_count
);
    import acpa_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ADD_RD = 4'd2;
    localparam logic [3:0] S_ADD_EV = 4'd3;
    localparam logic [3:0] S_AL_RD  = 4'd4;
    localparam logic [3:0] S_AL_EV  = 4'd5;
    localparam logic [3:0] S_TAKE   = 4'd6;
    localparam logic [3:0] S_PG_RD  = 4'd7;
    localparam logic [3:0] S_PG_EV  = 4'd8;
    localparam logic [3:0] S_REL_RD = 4'd9;
    localparam logic [3:0] S_REL_EV = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [10:0]          kend_reg, hstart_reg;
    logic [2:0]           kind_reg, kind_next;
    logic [AW:0]          cnt_reg, cnt_next;
    logic [3:0]           alog_reg, alog_next;
    logic [1:0]           rgn_reg, rgn_next;
    logic [AW-1:0]        p_reg, p_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [AW:0]          s_reg, s_next;
    logic [AW:0]          k_reg, k_next;
    logic [CW-1:0]        fn_reg, fn_next;
    logic [CW-1:0]        fh_reg, fh_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [AW-1:0]        bstart_reg, bstart_next;
    logic [REF_WIDTH-1:0] refs_reg, refs_next;

    logic                 st_we;
    page_t                st_wpage, st_rpage;
    logic [REF_WIDTH-1:0] st_wref, st_rref;
    logic [REF_WIDTH-1:0] ref_new;
    logic [1:0]           cls;
    logic [31:0]          jump;
    logic                 finish;

    acpa_page_store #(
        .NUM_PAGES(NUM_PAGES),
        .REF_WIDTH(REF_WIDTH),
        .AW(AW)
    ) u_store (
        .clk  (clk),
        .we   (st_we),
        .addr (p_reg),
        .wpage(st_wpage),
        .wref (st_wref),
        .rpage(st_rpage),
        .rref (st_rref)
    );

    always_comb
    begin
        if (32'(p_reg) < 32'(kend_reg))
            cls = REG_KERNEL;
        else if (32'(p_reg) < 32'(hstart_reg))
            cls = REG_NORMAL;
        else
            cls = REG_HIGH;
        jump = ((32'(p_reg) >> alog_reg) + 32'd1) << alog_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        cnt_next    = cnt_reg;
        alog_next   = alog_reg;
        rgn_next    = rgn_reg;
        p_next      = p_reg;
        last_next   = last_reg;
        s_next      = s_reg;
        k_next      = k_reg;
        fn_next     = fn_reg;
        fh_next     = fh_reg;
        status_next = status_reg;
        bstart_next = bstart_reg;
        refs_next   = refs_reg;
        finish      = 1'b0;
        st_we       = 1'b0;
        st_wpage    = '0;
        st_wref     = '0;
        ref_new     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                st_we = 1'b1;
                if (p_reg == LAST_PAGE)
                begin
                    p_next     = '0;
                    state_next = S_IDLE;
                end
                else
                    p_next = p_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    alog_next   = align_log2;
                    cnt_next    = (AW+1)'(page_count);
                    status_next = ST_OK;
                    bstart_next = '0;
                    refs_next   = '0;
                    k_next      = '0;
                    s_next      = '0;
                    unique case (kind) inside
                        OP_ADD_RANGE:
                        begin
                            if (page_count == 11'd0 ||
                                32'(page_index) + 32'(page_count) > NUM_PAGES)
                            begin
                                status_next = ST_BOUNDS;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                p_next     = AW'(page_index);
                                last_next  = AW'(32'(page_index) + 32'(page_count) - 32'd1);
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (page_count == 11'd0 || 32'(page_count) > NUM_PAGES)
                            begin
                                status_next = ST_BOUNDS;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                p_next     = '0;
                                rgn_next   = prefer_high ? REG_HIGH : REG_NORMAL;
                                state_next = S_AL_RD;
                            end
                        end
                        OP_FREE, OP_INCREF, OP_DECREF:
                        begin
                            if (32'(page_index) >= NUM_PAGES)
                            begin
                                status_next = ST_BOUNDS;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                p_next     = AW'(page_index);
                                state_next = S_PG_RD;
                            end
                        end
                        default:
                            finish = 1'b1;
                    endcase
                end
            end
            S_ADD_RD:
                state_next = S_ADD_EV;
            S_ADD_EV:
            begin
                if (st_rpage.region == REG_RESERVED)
                begin
                    st_we    = 1'b1;
                    st_wpage = '{used: 1'b0, blk_end: 1'b0, region: cls};
                    if (cls == REG_NORMAL)
                        fn_next = fn_reg + 1'b1;
                    else if (cls == REG_HIGH)
                        fh_next = fh_reg + 1'b1;
                end
                if (p_reg == last_reg)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_AL_RD:
                state_next = S_AL_EV;
            S_AL_EV:
            begin
                if (!st_rpage.used && st_rpage.region == rgn_reg)
                begin
                    if (k_reg + 1'b1 == cnt_reg)
                    begin
                        p_next     = AW'(s_reg);
                        k_next     = '0;
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        p_next     = p_reg + 1'b1;
                        state_next = S_AL_RD;
                    end
                end
                else if (jump + 32'(cnt_reg) <= NUM_PAGES)
                begin
                    s_next     = (AW+1)'(jump);
                    p_next     = AW'(jump);
                    k_next     = '0;
                    state_next = S_AL_RD;
                end
                else if (rgn_reg == REG_HIGH)
                begin
                    rgn_next   = REG_NORMAL;
                    s_next     = '0;
                    p_next     = '0;
                    k_next     = '0;
                    state_next = S_AL_RD;
                end
                else
                begin
                    status_next = ST_NO_SPACE;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TAKE:
            begin
                st_we    = 1'b1;
                st_wpage = '{used: 1'b1, blk_end: (k_reg + 1'b1 == cnt_reg), region: rgn_reg};
                if (k_reg + 1'b1 == cnt_reg)
                begin
                    if (rgn_reg == REG_HIGH)
                        fh_next = (fh_reg >= CW'(cnt_reg)) ? fh_reg - CW'(cnt_reg) : '0;
                    else
                        fn_next = (fn_reg >= CW'(cnt_reg)) ? fn_reg - CW'(cnt_reg) : '0;
                    bstart_next = AW'(s_reg);
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    p_next = p_reg + 1'b1;
                end
            end
            S_PG_RD:
                state_next = S_PG_EV;
            S_PG_EV:
            begin
                rgn_next = st_rpage.region;
                if ((st_rpage.region != REG_NORMAL && st_rpage.region != REG_HIGH) ||
                    !st_rpage.used)
                begin
                    status_next = ST_BAD_PAGE;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (kind_reg == OP_FREE)
                    state_next = S_REL_RD;
                else
                begin
                    if (kind_reg == OP_INCREF)
                        ref_new = (st_rref == REF_MAX) ? st_rref : st_rref + 1'b1;
                    else
                        ref_new = (st_rref != '0) ? st_rref - 1'b1 : '0;
                    st_we     = 1'b1;
                    st_wpage  = st_rpage;
                    st_wref   = ref_new;
                    refs_next = ref_new;
                    if (kind_reg == OP_DECREF && ref_new == '0)
                        state_next = S_REL_RD;
                    else
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_REL_RD:
                state_next = S_REL_EV;
            S_REL_EV:
            begin
                if (st_rpage.used && st_rpage.region == rgn_reg)
                begin
                    st_we    = 1'b1;
                    st_wpage = '{used: 1'b0, blk_end: 1'b0, region: rgn_reg};
                    if (rgn_reg == REG_HIGH)
                        fh_next = fh_reg + 1'b1;
                    else
                        fn_next = fn_reg + 1'b1;
                    if (st_rpage.blk_end || p_reg == LAST_PAGE)
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_REL_RD;
                    end
                end
                else
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        done_next = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            p_reg      <= '0;
            fn_reg     <= '0;
            fh_reg     <= '0;
            done_reg   <= 1'b0;
            kend_reg   <= 11'd0;
            hstart_reg <= 11'd1024;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            fn_reg    <= fn_next;
            fh_reg    <= fh_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == CFG_KERNEL_END)
                kend_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_HIGH_START)
                hstart_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        cnt_reg    <= cnt_next;
        alog_reg   <= alog_next;
        rgn_reg    <= rgn_next;
        last_reg   <= last_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        bstart_reg <= bstart_next;
        refs_reg   <= refs_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign block_start = 10'(bstart_reg);
    assign free_normal = 11'(fn_reg);
    assign free_high   = 11'(fh_reg);
    assign ref_count   = refs_reg;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither started nor finished");

    a_free_total: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fn_reg) + 32'(fh_reg)) <= NUM_PAGES)
        else $error("free page counts exceed page total");

    a_start_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && block_start != 10'd0) |-> (status == ST_OK))
        else $error("block start reported on failed transaction");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done)
        else $error("result strobe during store clear");

endmodule
`default_nettype wire
